FILE: hw/rtl/psd_pkg.sv
// Package for the per-stream sequence dedup block: sizes, status and op codes.
// No dependencies.
package psd_pkg;
    localparam int STREAM_SLOTS = 8;
    localparam int GAP_DEPTH    = 64;
    localparam int SLOT_W       = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int GIDX_W       = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
    localparam int GCNT_W       = $clog2(GAP_DEPTH + 1);
    localparam int GADDR_W      = SLOT_W + GIDX_W;
    localparam int GMEM_DEPTH   = STREAM_SLOTS * GAP_DEPTH;

    typedef enum logic [1:0] {
        OP_RECORD  = 2'd0,
        OP_CHECK   = 2'd1,
        OP_RESTORE = 2'd2,
        OP_BAD     = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_INVAL  = 3'd1;
    localparam logic [2:0] ST_NOSLOT = 3'd2;
    localparam logic [2:0] ST_EXISTS = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    localparam logic [0:0] REG_GAP_LIMIT = 1'd0;
endpackage

FILE: hw/rtl/psd_if.sv
// Valid/ready channel interfaces for the dedup block's request and result items.
// Depends on nothing.
interface psd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] stream_id;
    logic [63:0] sequence_req;
    modport source (output valid, op, stream_id, sequence_req, input ready);
    modport sink (input valid, op, stream_id, sequence_req, output ready);
endinterface

interface psd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        seen;
    logic [63:0] frontier_now;
    logic [6:0]  gap_count;
    modport source (output valid, status, seen, frontier_now, gap_count, input ready);
    modport sink (input valid, status, seen, frontier_now, gap_count, output ready);
endinterface

FILE: hw/rtl/per_stream_sequence_dedup_top.sv
// Per-stream sequence dedup block: one request item in, one result item out.
// Uses psd_pkg, psd_if and psd_ram.
//
// Tracks up to STREAM_SLOTS streams; each has a frontier and a sorted gap list
// in a gap RAM (one row of GAP_DEPTH entries per slot). The lookup scans one
// slot per cycle; each gap entry examined then goes through the single RAM
// read port (address, then compare), and each entry moved for a sorted insert
// or for compacting after a frontier absorb is read and then written back.
// One item is in flight at a time; the result sits in an output register, and
// the next item is taken once that result has been accepted.
module per_stream_sequence_dedup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psd_req_if.sink     i_req,
    psd_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_CLAIM, S_DISPATCH, S_SRCH_RD, S_SRCH_CHK,
        S_INS_RD, S_INS_WR, S_ABS_RD, S_ABS_CHK, S_SH_RD, S_SH_WR, S_DONE
    } t_state;

    localparam logic [1:0] GAP_LIMIT_ADDR = 2'({REG_GAP_LIMIT, 2'b00});

    t_state r_state;

    // Slot table held in flops (small, fixed-index).
    logic [63:0]       r_key   [STREAM_SLOTS];
    logic [63:0]       r_front [STREAM_SLOTS];
    logic [GCNT_W-1:0] r_gcnt  [STREAM_SLOTS];
    logic [6:0]        r_limit;

    // Per-item registers.
    logic [1:0]        r_op;
    logic [63:0]       r_sid, r_seq;
    logic [SLOT_W-1:0] r_idx, r_slot, r_free;
    logic              r_found, r_has_free;
    logic [GCNT_W-1:0] r_i, r_j, r_drop;
    logic [63:0]       r_fr;

    // Result register.
    logic              r_ovalid;
    logic [2:0]        r_status;
    logic              r_seen;
    logic [63:0]       r_ofront;
    logic [6:0]        r_ogcnt;

    // Gap RAM.
    logic               ram_we;
    logic [GADDR_W-1:0] ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;

    psd_ram #(.WIDTH(64), .DEPTH(GMEM_DEPTH)) u_gap_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    function automatic logic [GADDR_W-1:0] gaddr(logic [SLOT_W-1:0] s, logic [GCNT_W-1:0] i);
        return {s, i[GIDX_W-1:0]};
    endfunction

    logic [GCNT_W-1:0] lim_eff;
    assign lim_eff = (32'(r_limit) < GAP_DEPTH) ? GCNT_W'(r_limit) : GCNT_W'(GAP_DEPTH);

    // APB port: writes complete in the access cycle.
    assign pready = 1'b1;
    assign prdata = (paddr == GAP_LIMIT_ADDR) ? {25'd0, r_limit} : 32'd0;
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr == GAP_LIMIT_ADDR);

    assign i_req.ready = (r_state == S_IDLE) && (!r_ovalid || o_rsp.ready);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_status;
    assign o_rsp.seen = r_seen;
    assign o_rsp.frontier_now = r_ofront;
    assign o_rsp.gap_count = r_ogcnt;

    // RAM address and write control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = gaddr(r_slot, r_i);
        ram_wdata = ram_rdata;
        ram_raddr = gaddr(r_slot, r_i);
        case (r_state)
            S_INS_RD: ram_raddr = gaddr(r_slot, r_j - 1'b1);
            S_INS_WR: begin
                ram_we = 1'b1;
                if (r_j == r_i) begin
                    ram_waddr = gaddr(r_slot, r_i);
                    ram_wdata = r_seq;
                end else begin
                    ram_waddr = gaddr(r_slot, r_j);
                end
            end
            S_SH_RD: ram_raddr = gaddr(r_slot, r_j + r_drop);
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = gaddr(r_slot, r_j);
            end
            default: ;
        endcase
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_limit  <= 7'd64;
            for (int k = 0; k < STREAM_SLOTS; k++) begin
                r_key[k]   <= '0;
                r_front[k] <= '0;
                r_gcnt[k]  <= '0;
            end
        end else begin
            if (cfg_wr) r_limit <= pwdata[6:0];
            if (r_ovalid && o_rsp.ready && r_state != S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op <= i_req.op;
                        r_sid <= i_req.stream_id;
                        r_seq <= i_req.sequence_req;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_has_free <= 1'b0;
                        r_seen <= 1'b0;
                        r_status <= ST_OK;
                        r_state <= S_LOOK;
                    end
                end
                // Scan one slot per cycle for a key match and the first free slot.
                S_LOOK: begin
                    if (!r_found && r_key[r_idx] == r_sid) begin
                        r_found <= 1'b1;
                        r_slot <= r_idx;
                    end
                    if (!r_has_free && r_key[r_idx] == '0) begin
                        r_has_free <= 1'b1;
                        r_free <= r_idx;
                    end
                    if (32'(r_idx) == STREAM_SLOTS - 1) r_state <= S_CLAIM;
                    else r_idx <= r_idx + 1'b1;
                end
                // Decide errors and claim a slot if the op allocates.
                S_CLAIM: begin
                    if (r_sid == '0) begin
                        r_status <= ST_INVAL;
                        r_found <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_op == OP_CHECK) begin
                        if (r_found && r_seq != '0 && r_seq > r_front[r_slot]) begin
                            r_i <= '0;
                            r_state <= S_SRCH_RD;
                        end else begin
                            r_seen <= r_found && r_seq != '0;
                            r_state <= S_DONE;
                        end
                    end else if (r_op == OP_BAD || (r_op == OP_RECORD && r_seq == '0)) begin
                        r_status <= ST_INVAL;
                        r_state <= S_DONE;
                    end else if (r_found) begin
                        r_state <= S_DISPATCH;
                    end else if (r_has_free) begin
                        r_found <= 1'b1;
                        r_slot <= r_free;
                        r_key[r_free] <= r_sid;
                        r_front[r_free] <= '0;
                        r_gcnt[r_free] <= '0;
                        r_state <= S_DISPATCH;
                    end else begin
                        r_status <= ST_NOSLOT;
                        r_state <= S_DONE;
                    end
                end
                // A number at or below the frontier is a duplicate record or a
                // restore that does not move forward.
                S_DISPATCH: begin
                    r_fr <= r_seq;
                    r_i <= '0;
                    if (r_seq <= r_front[r_slot]) begin
                        if (r_op == OP_RECORD) r_status <= ST_EXISTS;
                        r_state <= S_DONE;
                    end else r_state <= S_SRCH_RD;
                end
                // Linear search: issue read of entry r_i.
                S_SRCH_RD: begin
                    if (r_i >= r_gcnt[r_slot]) begin
                        // End of list reached.
                        if (r_op == OP_CHECK) r_state <= S_DONE;
                        else if (r_op == OP_RECORD) begin
                            if (r_seq == r_front[r_slot] + 64'd1) begin
                                r_fr <= r_seq;
                                r_i <= '0;
                                r_state <= S_ABS_RD;
                            end else if (r_gcnt[r_slot] >= lim_eff) begin
                                r_status <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_j <= r_gcnt[r_slot];
                                r_state <= S_INS_RD;
                            end
                        end else begin
                            // Restore: every entry is covered; r_i counts them.
                            r_state <= S_ABS_RD;
                        end
                    end else r_state <= S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    if (r_op == OP_RESTORE) begin
                        if (ram_rdata <= r_seq) begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_SRCH_RD;
                        end else begin
                            r_state <= S_ABS_RD;
                        end
                    end else if (ram_rdata < r_seq) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SRCH_RD;
                    end else if (ram_rdata == r_seq) begin
                        if (r_op == OP_CHECK) r_seen <= 1'b1;
                        else r_status <= ST_EXISTS;
                        r_state <= S_DONE;
                    end else if (r_op == OP_CHECK) begin
                        r_state <= S_DONE;
                    end else if (r_seq == r_front[r_slot] + 64'd1) begin
                        r_fr <= r_seq;
                        r_i <= '0;
                        r_state <= S_ABS_RD;
                    end else if (r_gcnt[r_slot] >= lim_eff) begin
                        r_status <= ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_gcnt[r_slot];
                        r_state <= S_INS_RD;
                    end
                end
                // Sorted insert: shift entries up from the tail down to r_i.
                S_INS_RD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    if (r_j == r_i) begin
                        r_gcnt[r_slot] <= r_gcnt[r_slot] + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_j - 1'b1;
                        r_state <= (r_j - 1'b1 == r_i) ? S_INS_WR : S_INS_RD;
                    end
                end
                // Absorb: starting at entry r_i, count entries contiguous with
                // the new frontier. Entries below r_i are already covered.
                S_ABS_RD: begin
                    if (r_i >= r_gcnt[r_slot]) begin
                        r_front[r_slot] <= r_fr;
                        r_drop <= r_i;
                        r_j <= '0;
                        r_state <= S_SH_RD;
                    end else r_state <= S_ABS_CHK;
                end
                S_ABS_CHK: begin
                    if (ram_rdata == r_fr + 64'd1) begin
                        r_fr <= r_fr + 64'd1;
                        r_i <= r_i + 1'b1;
                        r_state <= S_ABS_RD;
                    end else begin
                        r_front[r_slot] <= r_fr;
                        r_drop <= r_i;
                        r_j <= '0;
                        r_state <= S_SH_RD;
                    end
                end
                // Compact: move entries down by r_drop.
                S_SH_RD: begin
                    if (r_drop == '0 || r_j + r_drop >= r_gcnt[r_slot]) begin
                        r_gcnt[r_slot] <= r_gcnt[r_slot] - r_drop;
                        r_state <= S_DONE;
                    end else r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_j <= r_j + 1'b1;
                    r_state <= S_SH_RD;
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_ofront <= r_found ? r_front[r_slot] : '0;
                        r_ogcnt  <= r_found ? 7'(r_gcnt[r_slot]) : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Assertions.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state != S_IDLE) else $error("item not started");
    a_gcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found) |-> (r_gcnt[r_slot] <= GCNT_W'(GAP_DEPTH)))
        else $error("gap count overflow");
    a_seen_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.seen) |-> o_rsp.status == ST_OK) else $error("seen with error");
endmodule

FILE: hw/rtl/psd_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module psd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
